### design/i2cabs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cabs_pkg
// Shared types and constants for the addressed I2C slave byte store.
// ----------------------------------------------------------------------------
package i2cabs_pkg;

	// Store size; a power of two, so the index is the low pointer bits.
	localparam int STORE_DEPTH = 256;
	localparam int IDX_W       = $clog2(STORE_DEPTH);

	typedef logic [1:0] op_t;

	localparam op_t OP_START = 2'd0;
	localparam op_t OP_ACK   = 2'd1;
	localparam op_t OP_NACK  = 2'd2;
	localparam op_t OP_STOP  = 2'd3;

	typedef logic [1:0] phase_t;

	localparam phase_t PH_ADDR  = 2'd0;
	localparam phase_t PH_WRITE = 2'd1;
	localparam phase_t PH_SEND  = 2'd2;

	localparam logic [1:0] CNT_ZERO = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	// Controller -> datapath
	typedef struct packed {
		logic clr_en;   // write zero at the clear counter, advance it
		logic accept;   // an item is taken this cycle
		logic rd_load;  // store read data is valid, load it into the result
	} ctrl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clr_last;   // clear counter at the last entry
		logic rd_needed;  // current item is an ack that reads the store
		logic out_valid;  // result register holds an item
	} dp_status_t;

endpackage

### design/i2cabs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cabs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cabs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/i2cabs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cabs_dp
// Datapath: protocol phase, byte count, pointer, byte store and result register.
// ----------------------------------------------------------------------------
module i2cabs_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2cabs_pkg::ctrl_cmd_t  cmd,
	output i2cabs_pkg::dp_status_t status,
	input  i2cabs_pkg::op_t        op,
	input  logic [7:0]             rx_byte,
	input  logic                   read_request,
	input  logic                   out_ready,
	output logic                   tx_load,
	output logic [7:0]             tx_byte,
	output logic                   write_done
);
	import i2cabs_pkg::*;

	phase_t           phase_q;
	logic [1:0]       byte_count_q;
	logic [7:0]       pointer_high_q;
	logic [15:0]      access_pointer_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             out_valid_q;
	logic             tx_load_q;
	logic [7:0]       tx_byte_q;
	logic             write_done_q;

	logic             is_ack;
	logic             in_write;
	logic             in_send;
	logic             rd_needed;
	logic             wr_store;
	logic             ram_we;
	logic             ram_re;
	logic [IDX_W-1:0] ram_addr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	assign is_ack    = (op == OP_ACK);
	assign in_write  = (phase_q == PH_WRITE);
	assign in_send   = (phase_q == PH_SEND);
	// phase code three behaves as the address phase
	assign rd_needed = is_ack && !in_write && !in_send && read_request;
	assign wr_store  = is_ack && in_write && (byte_count_q != CNT_ZERO)
		&& (byte_count_q != CNT_ONE);

	assign ram_we    = cmd.clr_en || (cmd.accept && wr_store);
	assign ram_re    = cmd.accept && rd_needed;
	assign ram_addr  = cmd.clr_en ? clr_cnt_q : access_pointer_q[IDX_W-1:0];
	assign ram_wdata = cmd.clr_en ? 8'd0 : rx_byte;

	i2cabs_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_ADDR;
			byte_count_q     <= CNT_ZERO;
			pointer_high_q   <= 8'd0;
			access_pointer_q <= 16'd0;
		end else if (cmd.accept) begin
			if (!is_ack) begin
				phase_q      <= PH_ADDR;
				byte_count_q <= CNT_ZERO;
			end else if (in_write) begin
				case (byte_count_q)
					CNT_ZERO: begin
						pointer_high_q <= rx_byte;
						byte_count_q   <= CNT_ONE;
					end
					CNT_ONE: begin
						access_pointer_q <= {pointer_high_q, rx_byte};
						byte_count_q     <= CNT_TWO;
					end
					default: begin
						byte_count_q <= CNT_ZERO;
					end
				endcase
			end else if (!in_send) begin
				byte_count_q <= CNT_ZERO;
				if (read_request) begin
					phase_q          <= PH_SEND;
					access_pointer_q <= access_pointer_q + 16'd1;
				end else begin
					phase_q <= PH_WRITE;
				end
			end
		end
	end

	// result register; a read ack loads it from the store read data, in the ST_READ state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_load || (cmd.accept && !rd_needed)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_load) begin
			tx_load_q    <= 1'b1;
			tx_byte_q    <= ram_rdata;
			write_done_q <= 1'b0;
		end else if (cmd.accept && !rd_needed) begin
			tx_load_q    <= 1'b0;
			tx_byte_q    <= 8'd0;
			write_done_q <= wr_store;
		end
	end

	assign status.clr_last  = &clr_cnt_q;
	assign status.rd_needed = rd_needed;
	assign status.out_valid = out_valid_q;

	assign tx_load    = tx_load_q;
	assign tx_byte    = tx_byte_q;
	assign write_done = write_done_q;

endmodule

### design/i2cabs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cabs_ctrl
// Controller: store clearing after reset, item acceptance, store read wait.
// ----------------------------------------------------------------------------
module i2cabs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   out_ready,
	input  i2cabs_pkg::dp_status_t status,
	output i2cabs_pkg::ctrl_cmd_t  cmd
);
	import i2cabs_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_READ  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// the result register is free or drains in this cycle
	assign in_ready = (state_q == ST_IDLE) && (!status.out_valid || out_ready);
	assign accept   = in_valid && in_ready;

	assign cmd.clr_en  = (state_q == ST_CLEAR);
	assign cmd.accept  = accept;
	assign cmd.rd_load = (state_q == ST_READ);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && status.rd_needed) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status.rd_needed |=> state_q == ST_READ)
		else $error("read ack did not enter the read wait");

	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_IDLE && status.out_valid)
		else $error("read data not loaded into the result register");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !status.out_valid)
		else $error("result register busy when store data arrives");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !in_ready && !status.out_valid)
		else $error("item traffic during the clearing pass");
`endif

endmodule

### design/i2c_slave_addressed_byte_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_addressed_byte_store
// Event-driven I2C slave byte store with a 16-bit pointer (EEPROM-like).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one bus event per item, op is start,
//   ack, nack or stop; acks carry rx_byte and read_request.
//   Output channel (out_valid/out_ready): exactly one result item per input
//   item, in order: tx_load/tx_byte for a byte fetched for the master,
//   write_done when a data byte went into the store.
//   Results: a result is valid in the cycle after its item is accepted; an ack
//   that reads the store passes first through the registered read port of the
//   store RAM and then into the result register.
//   Throughput: one item per cycle while results drain; after a read ack no
//   new item is taken until the store read data is in the result register.
//   Reset: phase, count and pointer clear at once; the store is then swept
//   to zero, one entry per cycle, all STORE_DEPTH (256) entries, with in_ready low.
//   Stall: the result register holds one item; while it waits for out_ready
//   no new item is taken, except in the cycle that the result is taken.
// ----------------------------------------------------------------------------
module i2c_slave_addressed_byte_store (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  i2cabs_pkg::op_t op,
	input  logic [7:0]      rx_byte,
	input  logic            read_request,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            tx_load,
	output logic [7:0]      tx_byte,
	output logic            write_done
);
	import i2cabs_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	i2cabs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	i2cabs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.op          (op),
		.rx_byte     (rx_byte),
		.read_request(read_request),
		.out_ready   (out_ready),
		.tx_load     (tx_load),
		.tx_byte     (tx_byte),
		.write_done  (write_done)
	);

	assign out_valid = status.out_valid;

endmodule
